### rtl/core/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and byte constants for the UTF-8 to BMP code unit decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_LEAD = 3'd1,
		ST_BAD_CONT = 3'd2,
		ST_OVERLONG = 3'd3,
		ST_TRUNC    = 3'd4
	} status_t;

	// One accepted input byte
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_text;
	} in_item_t;

	// One result code unit
	typedef struct packed {
		logic [15:0] code_unit;
		status_t     status;
		logic        last;
	} result_t;

	localparam logic [7:0] LEAD2_MIN   = 8'hC2;
	localparam logic [7:0] LEAD2_MAX   = 8'hDF;
	localparam logic [7:0] LEAD3_MIN   = 8'hE0;
	localparam logic [7:0] LEAD3_MAX   = 8'hEF;
	localparam logic [7:0] E0_MIN_CONT = 8'hA0;

	localparam logic [1:0] PEND_IDLE = 2'd0;
	localparam logic [1:0] PEND_ONE  = 2'd1;
	localparam logic [1:0] PEND_TWO  = 2'd2;

endpackage

### rtl/core/utf8d_in_reg.sv
// ----------------------------------------------------------------------------
// utf8d_in_reg
// Input stage register: holds one byte until the decode step consumes it.
// ----------------------------------------------------------------------------
module utf8d_in_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  utf8d_pkg::in_item_t in_item,
	input  logic                take,
	output logic                v_s1,
	output utf8d_pkg::in_item_t item_s1
);
	import utf8d_pkg::*;

	// Free when empty, or when the held byte leaves this cycle
	assign in_ready = !v_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

endmodule

### rtl/core/utf8d_dec.sv
// ----------------------------------------------------------------------------
// utf8d_dec
// Sequence state and single-byte decode: updates state, forms at most one result.
// ----------------------------------------------------------------------------
module utf8d_dec (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  utf8d_pkg::in_item_t item_s1,
	output logic                res_valid,
	output utf8d_pkg::result_t  res
);
	import utf8d_pkg::*;

	logic [1:0]  pend_q, pend_d;
	logic [11:0] part_q, part_d;
	logic        e0_q, e0_d;
	logic        emit;
	logic [7:0]  b;
	logic        eot;

	assign b   = item_s1.data_byte;
	assign eot = item_s1.end_of_text;

	always_comb begin
		emit          = 1'b0;
		res.code_unit = 16'h0000;
		res.status    = ST_OK;
		res.last      = eot;
		pend_d        = pend_q;
		part_d        = part_q;
		e0_d          = e0_q;

		if (pend_q == PEND_IDLE) begin
			if (!b[7]) begin
				emit          = 1'b1;
				res.code_unit = {8'h00, b};
			end else if (b inside {[LEAD2_MIN:LEAD2_MAX]}) begin
				pend_d = PEND_ONE;
				part_d = {7'd0, b[4:0]};
				e0_d   = 1'b0;
			end else if (b inside {[LEAD3_MIN:LEAD3_MAX]}) begin
				pend_d = PEND_TWO;
				part_d = {8'd0, b[3:0]};
				e0_d   = (b == LEAD3_MIN);
			end else begin
				emit       = 1'b1;
				res.status = ST_BAD_LEAD;
			end
		end else begin
			if (b[7:6] != 2'b10) begin
				emit       = 1'b1;
				res.status = ST_BAD_CONT;
			end else if ((pend_q == PEND_TWO) && e0_q && (b < E0_MIN_CONT)) begin
				emit       = 1'b1;
				res.status = ST_OVERLONG;
			end else if (pend_q == PEND_ONE) begin
				emit          = 1'b1;
				res.code_unit = {part_q[9:0], b[5:0]};
			end else begin
				pend_d = PEND_ONE;
				part_d = {part_q[5:0], b[5:0]};
				e0_d   = 1'b0;
			end
		end

		// End of text with a sequence still open: report truncation
		if (!emit && eot) begin
			emit       = 1'b1;
			res.status = ST_TRUNC;
		end

		// Any result closes the sequence
		if (emit) begin
			pend_d = PEND_IDLE;
			part_d = 12'd0;
			e0_d   = 1'b0;
		end
	end

	assign res_valid = fire && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= PEND_IDLE;
			part_q <= 12'd0;
			e0_q   <= 1'b0;
		end else if (fire) begin
			pend_q <= pend_d;
			part_q <= part_d;
			e0_q   <= e0_d;
		end
	end

endmodule

### rtl/core/utf8d_out_reg.sv
// ----------------------------------------------------------------------------
// utf8d_out_reg
// Result register: holds one code unit until the downstream side takes it.
// ----------------------------------------------------------------------------
module utf8d_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid,
	input  utf8d_pkg::result_t res,
	output logic               take,
	output logic               out_valid,
	input  logic               out_ready,
	output utf8d_pkg::result_t out_res
);
	import utf8d_pkg::*;

	// Register can load when empty or when its content is transferred now
	assign take = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) begin
			out_res <= res;
		end
	end

endmodule

### rtl/core/utf8_to_utf16_bmp_decoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_bmp_decoder
// Streams UTF-8 bytes in, 16-bit BMP code units out, one status per result.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                  | handshake
//  ---------+-----+------------------------------------------+----------------
//  s_axis   | in  | tdata[7:0] data_byte, tlast end_of_text  | tvalid/tready
//  m_axis   | out | tdata[15:0] code_unit, tuser[2:0] status, | tvalid/tready
//           |     | tlast last                               |
//
//  One byte per cycle sustained while m_axis does not stall: a byte is
//  held in the input register, is decoded against the sequence state and
//  lands in the result register, which drives m_axis. Bytes that open or
//  extend a sequence produce no result unless they carry end_of_text.
//  arst_n clears both valid flags and returns the sequence state to idle.
//  A stall on m_axis holds the result register; the input register keeps
//  one more byte, after which s_axis_tready drops.
//
module utf8_to_utf16_bmp_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [15:0] code_unit
	output logic [2:0]  m_axis_tuser,  // [2:0] status
	output logic        m_axis_tlast
);
	import utf8d_pkg::*;

	in_item_t in_item;
	in_item_t item_s1;
	logic     v_s1;
	logic     take;
	logic     fire;
	logic     res_valid;
	result_t  res;
	result_t  out_res;

	assign in_item.data_byte   = s_axis_tdata;
	assign in_item.end_of_text = s_axis_tlast;

	utf8d_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.take     (take),
		.v_s1     (v_s1),
		.item_s1  (item_s1)
	);

	// Decode the held byte whenever the result register can take its outcome
	assign fire = v_s1 && take;

	utf8d_dec u_dec (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.item_s1   (item_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	utf8d_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.take      (take),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (out_res)
	);

	assign m_axis_tdata = out_res.code_unit;
	assign m_axis_tuser = out_res.status;
	assign m_axis_tlast = out_res.last;

endmodule

### rtl/core/utf8d_checker.sv
// ----------------------------------------------------------------------------
// utf8d_checker
// Port-level checks on the decoder's result stream and input ready, bound to the top level.
// ----------------------------------------------------------------------------
module utf8d_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tready,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	input  logic        m_axis_tlast
);
	import utf8d_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// Error results carry no code unit
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_OK) |-> m_axis_tdata == 16'h0000)
		else $error("nonzero code unit on error result");

	// Truncation only ever comes from the end-of-text byte
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_TRUNC) |-> m_axis_tlast)
		else $error("truncated result without last");

	// The input only backs up behind a stalled result
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled while result side free");

endmodule

bind utf8_to_utf16_bmp_decoder utf8d_checker u_utf8d_checker (.*);
